>>> rtl/drgc_pkg.sv
`timescale 1ns / 1ps
package drgc_pkg;

    localparam int unsigned CODE_W = 4;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned NUM_W  = 13;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [CODE_W-1:0] CODE_NONE = 4'd15;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [NUM_W-1:0] PCT_SCALE = 13'd100;

    localparam logic [CODE_W-1:0] LETTER_TO_CODE [26] = '{
        4'd11, 4'd12, 4'd4,  4'd5,  4'd15, 4'd15, 4'd2,  4'd3,  4'd15,
        4'd15, 4'd7,  4'd15, 4'd6,  4'd8,  4'd15, 4'd15, 4'd15, 4'd14,
        4'd10, 4'd0,  4'd15, 4'd1,  4'd13, 4'd15, 4'd9,  4'd15
    };

    localparam logic [7:0] CODE_TO_ASCII [16] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h47, 8'h48, 8'h4B, 8'h4D,
        8'h4E, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h59, 8'h00
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              is_gc;
        logic              bad;
        logic              last;
    } item_t;

    function automatic item_t classify(input logic [7:0] ch, input logic last);
        logic [7:0] up;
        logic [7:0] ofs;
        item_t      it;
        up = ch;
        if (ch >= CH_LO_A && ch <= CH_LO_Z)
        begin
            up = ch - CASE_OFS;
        end
        ofs = up - CH_UP_A;
        it.code = CODE_NONE;
        if (up >= CH_UP_A && up <= CH_UP_Z)
        begin
            it.code = LETTER_TO_CODE[ofs[4:0]];
        end
        it.bad   = (it.code == CODE_NONE);
        it.is_gc = (up == CH_G) || (up == CH_C);
        it.last  = last;
        return it;
    endfunction

endpackage

>>> rtl/drgc_front.sv
`timescale 1ns / 1ps
module drgc_front (
    input  logic             start,
    input  logic             full,
    input  logic [7:0]       base_in,
    input  logic             end_of_sequence,
    output logic             push,
    output drgc_pkg::item_t  item
);

    assign push = start && !full;
    assign item = drgc_pkg::classify(base_in, end_of_sequence);

endmodule

>>> rtl/drgc_fifo.sv
`timescale 1ns / 1ps
module drgc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  drgc_pkg::item_t  push_item,
    input  logic             pop,
    output drgc_pkg::item_t  head_item,
    output logic             empty,
    output logic             full
);

    localparam int unsigned PW = $clog2(drgc_pkg::FIFO_DEPTH);
    localparam int unsigned CW = $clog2(drgc_pkg::FIFO_DEPTH + 1);

    drgc_pkg::item_t      slot_reg [drgc_pkg::FIFO_DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [CW-1:0]        count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(drgc_pkg::FIFO_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> rtl/drgc_back.sv
`timescale 1ns / 1ps
module drgc_back #(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  drgc_pkg::item_t               item,
    output logic                          pop,
    output logic                          result_valid,
    output logic [7:0]                    complement_out,
    output logic [drgc_pkg::STAT_W-1:0]   status,
    output logic [drgc_pkg::PCT_W-1:0]    gc_percent,
    output logic                          final_result
);

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned NW = drgc_pkg::NUM_W;
    localparam int unsigned QW = drgc_pkg::PCT_W;
    localparam int unsigned IW = $clog2(QW);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PREF = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [drgc_pkg::CODE_W-1:0] mem [MAX_LEN];

    logic [1:0]                   state_reg, state_next;
    logic [LW-1:0]                len_reg, len_next;
    logic [LW-1:0]                gc_reg, gc_next;
    logic [drgc_pkg::STAT_W-1:0]  err_reg, err_next;
    logic [NW-1:0]                rem_reg, rem_next;
    logic [QW-1:0]                quo_reg, quo_next;
    logic [IW-1:0]                bit_reg, bit_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [drgc_pkg::CODE_W-1:0]  rd_data_reg;
    logic                         strobe_reg, strobe_next;
    logic                         wr_en;
    logic [AW-1:0]                rd_addr;
    logic [NW-1:0]                den_shift;
    logic                         out_err;
    logic [drgc_pkg::STAT_W-1:0]  out_stat;
    logic                         out_last;

    assign pop       = (state_reg == S_LOAD) && item_valid;
    assign den_shift = NW'(len_reg) << bit_reg;
    assign rd_addr   = (state_reg == S_EMIT) ? (idx_reg - AW'(1)) : idx_reg;
    assign result_valid = strobe_reg;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        gc_next     = gc_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        bit_next    = bit_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        wr_en       = 1'b0;
        out_err     = 1'b0;
        out_stat    = err_reg;
        out_last    = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (pop)
                begin
                    if (item.bad)
                    begin
                        if (err_reg == drgc_pkg::ST_OK)
                        begin
                            err_next = drgc_pkg::ST_BAD;
                        end
                    end
                    else if (len_reg == LW'(MAX_LEN))
                    begin
                        if (err_reg == drgc_pkg::ST_OK)
                        begin
                            err_next = drgc_pkg::ST_LONG;
                        end
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LW'(1);
                        if (item.is_gc)
                        begin
                            gc_next = gc_reg + LW'(1);
                        end
                    end
                    if (item.last)
                    begin
                        if (err_next != drgc_pkg::ST_OK)
                        begin
                            out_err     = 1'b1;
                            out_stat    = err_next;
                            strobe_next = 1'b1;
                            len_next    = '0;
                            gc_next     = '0;
                            err_next    = drgc_pkg::ST_OK;
                        end
                        else
                        begin
                            rem_next   = NW'(gc_next) * drgc_pkg::PCT_SCALE;
                            quo_next   = '0;
                            bit_next   = IW'(QW - 1);
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (rem_reg >= den_shift)
                begin
                    rem_next = rem_reg - den_shift;
                    quo_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - IW'(1);
                if (bit_reg == '0)
                begin
                    idx_next   = AW'(len_reg - LW'(1));
                    state_next = S_PREF;
                end
            end
            S_PREF:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                idx_next    = idx_reg - AW'(1);
                if (idx_reg == '0)
                begin
                    out_last   = 1'b1;
                    len_next   = '0;
                    gc_next    = '0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[AW-1:0]] <= item.code;
        end
        rd_data_reg <= mem[rd_addr];
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        bit_reg     <= bit_next;
        idx_reg     <= idx_next;
        if (out_err)
        begin
            complement_out <= '0;
            status         <= out_stat;
            gc_percent     <= '0;
            final_result   <= 1'b1;
        end
        else if (strobe_next)
        begin
            complement_out <= drgc_pkg::CODE_TO_ASCII[rd_data_reg];
            status         <= drgc_pkg::ST_OK;
            gc_percent     <= quo_reg;
            final_result   <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            len_reg    <= '0;
            gc_reg     <= '0;
            err_reg    <= drgc_pkg::ST_OK;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            gc_reg     <= gc_next;
            err_reg    <= err_next;
            strobe_reg <= strobe_next;
        end
    end

endmodule

>>> rtl/dna_revcomp_gc_engine.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// input    | start high, busy low | base_in, end_of_sequence
// result   | result_valid, 1 cycle| complement_out, status, gc_percent, final_result
//
// Characters enter a two-entry queue; the back end drains one per cycle while
// loading. After the marked character the divider forms the GC percentage bit
// by bit, a prefetch reads the store, then one result per cycle from it, reversed.
// An error sequence gives its single result, registered once the back end pops
// the marked character. busy rises only while the queue is full. Results are
// never held off. rst_n clears the FSM, length, GC, error and queue state.
module dna_revcomp_gc_engine #(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    base_in,
    input  logic                          end_of_sequence,
    output logic                          result_valid,
    output logic [7:0]                    complement_out,
    output logic [drgc_pkg::STAT_W-1:0]   status,
    output logic [drgc_pkg::PCT_W-1:0]    gc_percent,
    output logic                          final_result
);

    logic             push;
    logic             fifo_empty;
    logic             fifo_full;
    logic             pop;
    drgc_pkg::item_t  in_item;
    drgc_pkg::item_t  head_item;

    assign busy = fifo_full;

    drgc_front u_front (
        .start           (start),
        .full            (fifo_full),
        .base_in         (base_in),
        .end_of_sequence (end_of_sequence),
        .push            (push),
        .item            (in_item)
    );

    drgc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    drgc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (!fifo_empty),
        .item           (head_item),
        .pop            (pop),
        .result_valid   (result_valid),
        .complement_out (complement_out),
        .status         (status),
        .gc_percent     (gc_percent),
        .final_result   (final_result)
    );

endmodule
